FILE: rtl/assert_macros.svh
// Assertion macros shared by the interval bin count RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed: invariant violated");

// Check that a condition in one cycle implies another in the next
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check violated");

`endif

FILE: rtl/ibcm_pkg.sv
// Package for the interval bin count matrix: field widths, codes and shared types.
// No dependencies; imported by ibcm_matrix and interval_bin_count_matrix.
`timescale 1ns / 1ps

package ibcm_pkg;

	// Default sizes of the bin table and the count matrix
	localparam int MAX_BINS_DEF    = 1024;
	localparam int MAX_SAMPLES_DEF = 64;

	// Field and register widths
	localparam int WORD_W     = 32;
	localparam int REQ_W      = 2;
	localparam int BIDX_W     = 10;
	localparam int SLEN_W     = 16;
	localparam int SAMP_W     = 6;
	localparam int CNT_W      = 16;
	localparam int STATUS_W   = 3;
	localparam int BC_W       = 11;
	localparam int SC_W       = 7;
	localparam int TOL_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHIMERA_TOL  = 2'd2;

	// Request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_LOAD = 2'd0,
		REQ_HIT  = 2'd1,
		REQ_READ = 2'd2
	} ibcm_req_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_COUNTED  = 3'd0,
		ST_UNMAPPED = 3'd1,
		ST_CHIMERA  = 3'd2,
		ST_BELOW    = 3'd3,
		ST_DONE     = 3'd4
	} ibcm_status_t;

	// Count matrix access request
	typedef struct packed {
		logic rd;
		logic wr;
	} ibcm_mreq_t;

endpackage

FILE: rtl/ibcm_matrix.sv
// Bin-by-sample count matrix: two-port synchronous memory with a clearing sweep.
// Depends on ibcm_pkg for the request struct and word width.
`timescale 1ns / 1ps

module ibcm_matrix
	import ibcm_pkg::*;
#(
	parameter int MAX_BINS    = MAX_BINS_DEF,
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
	localparam int DEPTH      = MAX_BINS * MAX_SAMPLES,
	localparam int ADDR_W     = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ibcm_mreq_t        req,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WORD_W-1:0] wdata,
	output logic [WORD_W-1:0] rdata,
	output logic              busy
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic              busy_q;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [WORD_W-1:0] wdata_mux;

	// Sweep every cell to zero after reset, one cell per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
		end
	end

	// Steer the write port to the sweep while it runs
	always_comb begin
		we        = busy_q | req.wr;
		waddr     = busy_q ? clr_addr_q : addr;
		wdata_mux = busy_q ? '0 : wdata;
	end

	// Memory array with registered read data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata_mux;
		end
		if (req.rd) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;
	assign busy  = busy_q;

endmodule

FILE: rtl/interval_bin_count_matrix.sv
// Interval bin count matrix, top level. Uses ibcm_pkg, ibcm_matrix, assert_macros.svh.
//
// Input channel (in_valid / in_stall) carries one request item: load a bin start into
// the table, count an alignment hit, or read one count cell. Output channel
// (out_valid / out_stall) returns exactly one result item per request, in order.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user must do so
// only while the block is idle, which the block itself does not enforce.
// One item is worked on at a time. A load, an unmapped hit or an out-of-range cell read
// goes straight to the result; a hit below the first start stops after reading it; a
// cell read forms the address, then reads the cell. A mapped hit runs a binary search
// reading one bin table entry per cycle, then one bin table read for the chimera check
// unless its bin is last in use, then a read-modify-write of the cell if the sample is
// in range; a chimeric hit skips the cell. A new item is taken the cycle after the
// previous result enters the output register.
// Reset clears the totals, then sweeps the count matrix to zero, one cell per cycle,
// all MAX_BINS * MAX_SAMPLES cells (65536 by default); in_stall stays high during
// the sweep. The bin table is not cleared and must be loaded before use. When the
// receiver stalls, the result waits in the output register and the block holds its
// finished item until the register frees up.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module interval_bin_count_matrix
	import ibcm_pkg::*;
#(
	parameter int MAX_BINS    = MAX_BINS_DEF,
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// request channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [REQ_W-1:0]      req_type,
	input  logic [BIDX_W-1:0]     boundary_index,
	input  logic [WORD_W-1:0]     boundary_value,
	input  logic [WORD_W-1:0]     align_pos,
	input  logic [SLEN_W-1:0]     seq_length,
	input  logic                  unmapped,
	input  logic [SAMP_W-1:0]     sample_index,
	input  logic [CNT_W-1:0]      read_count,
	input  logic [BIDX_W-1:0]     query_bin,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [STATUS_W-1:0]   status,
	output logic [BIDX_W-1:0]     bin_index,
	output logic [WORD_W-1:0]     cell_value,
	output logic [WORD_W-1:0]     total_reads,
	output logic [WORD_W-1:0]     chimera_total
);

	localparam int BIN_W  = $clog2(MAX_BINS);
	localparam int NB_W   = $clog2(MAX_BINS + 1);
	localparam int NS_W   = $clog2(MAX_SAMPLES + 1);
	localparam int ADDR_W = $clog2(MAX_BINS * MAX_SAMPLES);
	localparam int PROD_W = BIN_W + NS_W;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_BASE  = 8'b0000_0010,
		S_SRCH  = 8'b0000_0100,
		S_NEXT  = 8'b0000_1000,
		S_MADDR = 8'b0001_0000,
		S_MRD   = 8'b0010_0000,
		S_MWB   = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	// configuration registers
	logic [BC_W-1:0]   bin_count_q;
	logic [SC_W-1:0]   sample_count_q;
	logic [TOL_W-1:0]  tol_q;
	logic [NB_W-1:0]   nb;
	logic [NS_W-1:0]   ns;

	// sequencer and item registers
	state_t            state_q, state_d;
	logic [BIN_W-1:0]  lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
	logic [WORD_W-1:0] pos_q, pos_d;
	logic [SLEN_W-1:0] slen_q, slen_d;
	logic [SAMP_W-1:0] samp_q, samp_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              rd_mode_q, rd_mode_d;
	logic [ADDR_W-1:0] maddr_q, maddr_d;
	ibcm_status_t      res_status_q, res_status_d;
	logic [BIDX_W-1:0] res_bin_q, res_bin_d;
	logic [WORD_W-1:0] res_cell_q, res_cell_d;
	logic [WORD_W-1:0] reads_sum_q, reads_sum_d;
	logic [WORD_W-1:0] chimera_sum_q, chimera_sum_d;

	// output register
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [BIDX_W-1:0]   bin_index_q;
	logic [WORD_W-1:0]   cell_value_q;
	logic [WORD_W-1:0]   total_reads_q;
	logic [WORD_W-1:0]   chimera_total_q;
	logic                out_free;

	// bin table memory
	logic [WORD_W-1:0] bin_mem [MAX_BINS];
	logic [WORD_W-1:0] bs_rdata_q;
	logic              bs_we, bs_re;
	logic [BIN_W-1:0]  bs_waddr, bs_raddr;

	// count matrix port
	ibcm_mreq_t        mreq;
	logic [WORD_W-1:0] m_rdata;
	logic              clr_busy;

	// search and arithmetic helpers
	logic              in_acc;
	logic [BIN_W-1:0]  lo_n, hi_n, mid_n;
	logic [BIN_W:0]    span;
	logic              srch_more, next_ok, samp_ok, in_samp_ok;
	logic              srch_step, count_go;
	logic              chim;
	logic              srch_win_ok;
	logic [WORD_W:0]   cell_sum, reads_sum_ext;
	logic [WORD_W-1:0] cell_sat;
	logic [PROD_W-1:0] prod;

	// Clamp the configured sizes to their usable range
	always_comb begin
		if (bin_count_q == '0) begin
			nb = NB_W'(1);
		end else if (32'(bin_count_q) > 32'(MAX_BINS)) begin
			nb = NB_W'(MAX_BINS);
		end else begin
			nb = NB_W'(bin_count_q);
		end
		if (sample_count_q == '0) begin
			ns = NS_W'(1);
		end else if (32'(sample_count_q) > 32'(MAX_SAMPLES)) begin
			ns = NS_W'(MAX_SAMPLES);
		end else begin
			ns = NS_W'(sample_count_q);
		end
	end

	// Narrow the search window by the table entry read last cycle
	always_comb begin
		lo_n = lo_q;
		hi_n = hi_q;
		if (state_q == S_SRCH) begin
			if (bs_rdata_q <= pos_q) begin
				lo_n = mid_q;
			end else begin
				hi_n = mid_q - BIN_W'(1);
			end
		end
		span      = {1'b0, hi_n} - {1'b0, lo_n} + (BIN_W + 1)'(1);
		mid_n     = lo_n + span[BIN_W:1];
		srch_more = lo_n < hi_n;
		next_ok   = (32'(lo_n) + 32'd1) < 32'(nb);
	end

	// Datapath arithmetic
	always_comb begin
		samp_ok       = 32'(samp_q) < 32'(ns);
		in_samp_ok    = 32'(sample_index) < 32'(ns);
		chim          = ({1'b0, pos_q} + (WORD_W + 1)'(slen_q)) >
		                ({1'b0, bs_rdata_q} + (WORD_W + 1)'(tol_q));
		cell_sum      = {1'b0, m_rdata} + (WORD_W + 1)'(cnt_q);
		cell_sat      = cell_sum[WORD_W] ? '1 : cell_sum[WORD_W-1:0];
		reads_sum_ext = {1'b0, reads_sum_q} + (WORD_W + 1)'(cnt_q);
		prod          = PROD_W'(lo_q) * PROD_W'(ns) + PROD_W'(samp_q);
	end

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || clr_busy;
	assign bs_waddr = BIN_W'(boundary_index);

	// Search window check for the probe held in mid_q
	assign srch_win_ok = (state_q != S_SRCH) ||
	                     ((lo_q < hi_q) && (mid_q > lo_q) && (mid_q <= hi_q));

	// Sequence one item: table load, cell read, or search, chimera check, cell update, result
	always_comb begin
		state_d       = state_q;
		lo_d          = lo_q;
		hi_d          = hi_q;
		mid_d         = mid_q;
		pos_d         = pos_q;
		slen_d        = slen_q;
		samp_d        = samp_q;
		cnt_d         = cnt_q;
		rd_mode_d     = rd_mode_q;
		maddr_d       = maddr_q;
		res_status_d  = res_status_q;
		res_bin_d     = res_bin_q;
		res_cell_d    = res_cell_q;
		reads_sum_d   = reads_sum_q;
		chimera_sum_d = chimera_sum_q;
		bs_we         = 1'b0;
		bs_re         = 1'b0;
		bs_raddr      = mid_n;
		mreq          = '0;
		srch_step     = 1'b0;
		count_go      = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					pos_d      = align_pos;
					slen_d     = seq_length;
					samp_d     = sample_index;
					cnt_d      = read_count;
					lo_d       = '0;
					hi_d       = BIN_W'(nb - NB_W'(1));
					res_cell_d = '0;
					res_bin_d  = '0;
					case (req_type)
						REQ_LOAD: begin
							bs_we        = 32'(boundary_index) < 32'(MAX_BINS);
							res_status_d = ST_DONE;
							res_bin_d    = boundary_index;
							state_d      = S_DONE;
						end
						REQ_HIT: begin
							rd_mode_d = 1'b0;
							if (unmapped) begin
								res_status_d = ST_UNMAPPED;
								state_d      = S_DONE;
							end else begin
								bs_re    = 1'b1;
								bs_raddr = '0;
								state_d  = S_BASE;
							end
						end
						REQ_READ: begin
							rd_mode_d = 1'b1;
							if ((32'(query_bin) < 32'(nb)) && in_samp_ok) begin
								lo_d    = BIN_W'(query_bin);
								state_d = S_MADDR;
							end else begin
								res_status_d = ST_DONE;
								res_bin_d    = query_bin;
								state_d      = S_DONE;
							end
						end
						default: begin
							res_status_d = ST_DONE;
							state_d      = S_DONE;
						end
					endcase
				end
			end
			S_BASE: begin
				if (pos_q < bs_rdata_q) begin
					res_status_d = ST_BELOW;
					state_d      = S_DONE;
				end else begin
					srch_step = 1'b1;
				end
			end
			S_SRCH: begin
				srch_step = 1'b1;
			end
			S_NEXT: begin
				if (chim) begin
					chimera_sum_d = (chimera_sum_q == '1) ? chimera_sum_q
					                                      : chimera_sum_q + WORD_W'(1);
					res_status_d  = ST_CHIMERA;
					res_bin_d     = BIDX_W'(lo_q);
					state_d       = S_DONE;
				end else begin
					count_go = 1'b1;
				end
			end
			S_MADDR: begin
				maddr_d = ADDR_W'(prod);
				state_d = S_MRD;
			end
			S_MRD: begin
				mreq.rd = 1'b1;
				state_d = S_MWB;
			end
			S_MWB: begin
				res_bin_d = BIDX_W'(lo_q);
				if (rd_mode_q) begin
					res_status_d = ST_DONE;
					res_cell_d   = m_rdata;
				end else begin
					mreq.wr      = 1'b1;
					res_status_d = ST_COUNTED;
					res_cell_d   = cell_sat;
					reads_sum_d  = reads_sum_ext[WORD_W] ? '1 : reads_sum_ext[WORD_W-1:0];
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// Step the search, or go to the chimera check, or for the last bin straight to counting
		if (srch_step) begin
			lo_d = lo_n;
			hi_d = hi_n;
			if (srch_more) begin
				mid_d    = mid_n;
				bs_re    = 1'b1;
				bs_raddr = mid_n;
				state_d  = S_SRCH;
			end else if (next_ok) begin
				bs_re    = 1'b1;
				bs_raddr = lo_n + BIN_W'(1);
				state_d  = S_NEXT;
			end else begin
				count_go = 1'b1;
			end
		end

		// Credit the cell, or drop the update for a sample out of range
		if (count_go) begin
			if (samp_ok) begin
				state_d = S_MADDR;
			end else begin
				res_status_d = ST_COUNTED;
				res_bin_d    = BIDX_W'(lo_n);
				res_cell_d   = '0;
				state_d      = S_DONE;
			end
		end
	end

	// Control state and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			reads_sum_q   <= '0;
			chimera_sum_q <= '0;
		end else begin
			state_q       <= state_d;
			reads_sum_q   <= reads_sum_d;
			chimera_sum_q <= chimera_sum_d;
		end
	end

	// Item payload registers
	always_ff @(posedge clk) begin
		lo_q         <= lo_d;
		hi_q         <= hi_d;
		mid_q        <= mid_d;
		pos_q        <= pos_d;
		slen_q       <= slen_d;
		samp_q       <= samp_d;
		cnt_q        <= cnt_d;
		rd_mode_q    <= rd_mode_d;
		maddr_q      <= maddr_d;
		res_status_q <= res_status_d;
		res_bin_q    <= res_bin_d;
		res_cell_q   <= res_cell_d;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_count_q    <= BC_W'(1);
			sample_count_q <= SC_W'(1);
			tol_q          <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BIN_COUNT:    bin_count_q    <= cfg_data[BC_W-1:0];
				CFG_SAMPLE_COUNT: sample_count_q <= cfg_data[SC_W-1:0];
				CFG_CHIMERA_TOL:  tol_q          <= cfg_data[TOL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Bin table: write on load, registered read for the search and the chimera check
	always_ff @(posedge clk) begin
		if (bs_we) begin
			bin_mem[bs_waddr] <= boundary_value;
		end
		if (bs_re) begin
			bs_rdata_q <= bin_mem[bs_raddr];
		end
	end

	// Output register: load the finished item, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			status_q        <= res_status_q;
			bin_index_q     <= res_bin_q;
			cell_value_q    <= res_cell_q;
			total_reads_q   <= reads_sum_q;
			chimera_total_q <= chimera_sum_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign bin_index     = bin_index_q;
	assign cell_value    = cell_value_q;
	assign total_reads   = total_reads_q;
	assign chimera_total = chimera_total_q;

	ibcm_matrix #(
		.MAX_BINS    (MAX_BINS),
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_matrix (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.addr   (maddr_q),
		.wdata  (cell_sat),
		.rdata  (m_rdata),
		.busy   (clr_busy)
	);

	// Cell updates never collide with the clearing sweep
	`ASSERT_HOLDS(a_wr_not_clearing, clk, arst_n, !(mreq.wr && clr_busy))
	// Search window stays open and the probe lies inside it
	`ASSERT_HOLDS(a_search_window, clk, arst_n, srch_win_ok)
	// Chimera total moves only on the chimera check
	`ASSERT_NEXT(a_chim_only_check, clk, arst_n, state_q != S_NEXT, $stable(chimera_sum_q))
	// A finished item with a free output register shows up and frees the sequencer
	`ASSERT_NEXT(a_done_to_out, clk, arst_n, (state_q == S_DONE) && out_free, out_valid_q && (state_q == S_IDLE))

endmodule

FILE: test/tb_interval_bin_count_matrix.sv
`timescale 1ns / 1ps
// Testbench for interval_bin_count_matrix: loads bin tables, sends hits and cell reads,
// and checks every result item in order against a scoreboard that tracks the matrix.
// Depends on ibcm_pkg and the interval_bin_count_matrix RTL.

module tb_interval_bin_count_matrix;
	import ibcm_pkg::*;

	localparam int NUM_BINS    = MAX_BINS_DEF;
	localparam int NUM_SAMPLES = MAX_SAMPLES_DEF;
	localparam int NUM_CELLS   = NUM_BINS * NUM_SAMPLES;

	localparam logic [REQ_W-1:0]  REQ_UNKNOWN = 2'd3;
	localparam logic [WORD_W-1:0] WORD_MAX    = '1;

	localparam int CYCLE_LIMIT   = 4000000;
	localparam int SETTLE_CYCLES = 40;
	localparam int IDLE_PCT      = 22;
	localparam int HOLD_CYCLES   = 400;
	localparam int HAMMER_HITS   = 30;

	// One request item as presented on the input channel
	typedef struct {
		logic [REQ_W-1:0]  req;
		logic [BIDX_W-1:0] bidx;
		logic [WORD_W-1:0] bval;
		logic [WORD_W-1:0] pos;
		logic [SLEN_W-1:0] slen;
		logic              unm;
		logic [SAMP_W-1:0] samp;
		logic [CNT_W-1:0]  cnt;
		logic [BIDX_W-1:0] qbin;
	} bin_req_t;

	// One result item
	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [BIDX_W-1:0]   bin;
		logic [WORD_W-1:0]   cell_val;
		logic [WORD_W-1:0]   reads;
		logic [WORD_W-1:0]   chimeras;
	} bin_result_t;

	// Tracks the bin table, count matrix and totals; predicts and checks results
	class matrix_ledger;
		logic [WORD_W-1:0] starts [NUM_BINS];
		logic [WORD_W-1:0] cells [NUM_CELLS];
		logic [WORD_W-1:0] reads_sum;
		logic [WORD_W-1:0] chimera_sum;
		logic [BC_W-1:0]   bin_count;
		logic [SC_W-1:0]   sample_count;
		logic [TOL_W-1:0]  tolerance;
		bin_result_t       results_due [$];
		int                mismatches;

		function new();
			foreach (starts[i]) starts[i] = '0;
			foreach (cells[i]) cells[i] = '0;
			reads_sum    = '0;
			chimera_sum  = '0;
			bin_count    = BC_W'(1);
			sample_count = SC_W'(1);
			tolerance    = '0;
			mismatches   = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_BIN_COUNT:    bin_count = data[BC_W-1:0];
				CFG_SAMPLE_COUNT: sample_count = data[SC_W-1:0];
				CFG_CHIMERA_TOL:  tolerance = data[TOL_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [WORD_W-1:0] add_clipped(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
			logic [WORD_W:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[WORD_W] ? WORD_MAX : s[WORD_W-1:0];
		endfunction

		function int unsigned bins_in_use();
			if (bin_count == 0) return 1;
			if (bin_count > NUM_BINS) return NUM_BINS;
			return bin_count;
		endfunction

		function int unsigned samples_in_use();
			if (sample_count == 0) return 1;
			if (sample_count > NUM_SAMPLES) return NUM_SAMPLES;
			return sample_count;
		endfunction

		// Largest entry below nb whose start is not above pos, probed like the hardware
		function int unsigned search_bin(logic [WORD_W-1:0] pos, int unsigned nb);
			int unsigned lo, hi, mid;
			lo = 0;
			hi = nb - 1;
			while (lo < hi) begin
				mid = lo + ((hi - lo + 1) >> 1);
				if (starts[mid] <= pos) lo = mid;
				else hi = mid - 1;
			end
			return lo;
		endfunction

		// Apply one accepted item and queue the result it must produce
		function void post_request(bin_req_t it);
			bin_result_t r;
			int unsigned nb, ns, bin, addr;
			logic [WORD_W+1:0] reach, limit;
			nb = bins_in_use();
			ns = samples_in_use();
			r.status   = ST_DONE;
			r.bin      = '0;
			r.cell_val = '0;
			case (it.req)
				REQ_LOAD: begin
					starts[it.bidx] = it.bval;
					r.bin = it.bidx;
				end
				REQ_HIT: begin
					if (it.unm) begin
						r.status = ST_UNMAPPED;
					end else if (it.pos < starts[0]) begin
						r.status = ST_BELOW;
					end else begin
						bin = search_bin(it.pos, nb);
						r.bin = BIDX_W'(bin);
						r.status = ST_COUNTED;
						// the last bin in use has no end to check against
						if (bin + 1 < nb) begin
							reach = {2'b00, it.pos} + {18'd0, it.slen};
							limit = {2'b00, starts[bin + 1]} + {18'd0, tolerance};
							if (reach > limit) r.status = ST_CHIMERA;
						end
						if (r.status == ST_CHIMERA) begin
							chimera_sum = add_clipped(chimera_sum, 32'd1);
						end else if (it.samp < ns) begin
							addr = bin * ns + it.samp;
							cells[addr] = add_clipped(cells[addr], {16'd0, it.cnt});
							r.cell_val = cells[addr];
							reads_sum = add_clipped(reads_sum, {16'd0, it.cnt});
						end
					end
				end
				REQ_READ: begin
					r.bin = it.qbin;
					if (it.qbin < nb && it.samp < ns) r.cell_val = cells[it.qbin * ns + it.samp];
				end
				default: ;
			endcase
			r.reads    = reads_sum;
			r.chimeras = chimera_sum;
			results_due.push_back(r);
		endfunction

		// Compare one accepted result with the oldest outstanding one
		function void match_answer(bin_result_t got);
			bin_result_t want;
			if (results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result with none outstanding: status=%0d bin=%0d cell=%h",
						got.status, got.bin, got.cell_val);
				return;
			end
			want = results_due.pop_front();
			if (got.status !== want.status || got.bin !== want.bin ||
			    got.cell_val !== want.cell_val ||
			    got.reads !== want.reads || got.chimeras !== want.chimeras) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("ERROR: expected status=%0d bin=%0d cell=%h reads=%h chimeras=%h",
						want.status, want.bin, want.cell_val, want.reads, want.chimeras);
					$display("       actual   status=%0d bin=%0d cell=%h reads=%h chimeras=%h",
						got.status, got.bin, got.cell_val, got.reads, got.chimeras);
				end
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [REQ_W-1:0]      req_type = '0;
	logic [BIDX_W-1:0]     boundary_index = '0;
	logic [WORD_W-1:0]     boundary_value = '0;
	logic [WORD_W-1:0]     align_pos = '0;
	logic [SLEN_W-1:0]     seq_length = '0;
	logic                  unmapped = 1'b0;
	logic [SAMP_W-1:0]     sample_index = '0;
	logic [CNT_W-1:0]      read_count = '0;
	logic [BIDX_W-1:0]     query_bin = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [STATUS_W-1:0]   status;
	logic [BIDX_W-1:0]     bin_index;
	logic [WORD_W-1:0]     cell_value;
	logic [WORD_W-1:0]     total_reads;
	logic [WORD_W-1:0]     chimera_total;

	matrix_ledger      ledger = new();
	bin_result_t       seen;
	logic [WORD_W-1:0] plan_starts [NUM_BINS];
	int unsigned       cur_bins = 1;
	int unsigned       cur_samples = 1;
	int unsigned       cur_tol = 0;
	int unsigned       cycles = 0;
	bit                gap_on = 1'b1;
	bit                stall_on = 1'b1;
	int                hold_left = 0;

	interval_bin_count_matrix dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.boundary_index (boundary_index),
		.boundary_value (boundary_value),
		.align_pos      (align_pos),
		.seq_length     (seq_length),
		.unmapped       (unmapped),
		.sample_index   (sample_index),
		.read_count     (read_count),
		.query_bin      (query_bin),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.bin_index      (bin_index),
		.cell_value     (cell_value),
		.total_reads    (total_reads),
		.chimera_total  (chimera_total)
	);

	always #5 clk = ~clk;

	// Bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("interval_bin_count_matrix verification failed");
			$finish;
		end
	end

	// Receiver: random stalls, plus a long hold-off when one is requested
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			out_stall <= stall_on && ($urandom_range(99, 0) < IDLE_PCT);
		end
	end

	// Check each accepted result item
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			seen.status   = status;
			seen.bin      = bin_index;
			seen.cell_val = cell_value;
			seen.reads    = total_reads;
			seen.chimeras = chimera_total;
			ledger.match_answer(seen);
		end
	end

	// Present one item, hold it until accepted, then note it
	task automatic send_item(input bin_req_t it);
		while (gap_on && $urandom_range(99, 0) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		req_type       <= it.req;
		boundary_index <= it.bidx;
		boundary_value <= it.bval;
		align_pos      <= it.pos;
		seq_length     <= it.slen;
		unmapped       <= it.unm;
		sample_index   <= it.samp;
		read_count     <= it.cnt;
		query_bin      <= it.qbin;
		in_valid       <= 1'b1;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		ledger.post_request(it);
		@(negedge clk);
	endtask

	// Stop offering items and wait until every result has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (ledger.results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic put_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		ledger.write_register(idx, data);
		@(negedge clk);
	endtask

	task automatic write_config(int unsigned nbins, int unsigned samples, int unsigned tol);
		drain();
		put_register(CFG_BIN_COUNT, CFG_DATA_W'(nbins));
		put_register(CFG_SAMPLE_COUNT, CFG_DATA_W'(samples));
		put_register(CFG_CHIMERA_TOL, CFG_DATA_W'(tol));
		cfg_we <= 1'b0;
		@(negedge clk);
		cur_bins    = nbins;
		cur_samples = samples;
		cur_tol     = tol;
	endtask

	function automatic bin_req_t random_fields();
		bin_req_t it;
		it.req  = REQ_W'($urandom_range(2, 0));
		it.bidx = BIDX_W'($urandom());
		it.bval = $urandom();
		it.pos  = $urandom();
		it.slen = SLEN_W'($urandom());
		it.unm  = 1'($urandom());
		it.samp = SAMP_W'($urandom());
		it.cnt  = CNT_W'($urandom());
		it.qbin = BIDX_W'($urandom());
		return it;
	endfunction

	function automatic bin_req_t load_req(int unsigned idx, logic [WORD_W-1:0] val);
		bin_req_t it;
		it      = random_fields();
		it.req  = REQ_LOAD;
		it.bidx = BIDX_W'(idx);
		it.bval = val;
		return it;
	endfunction

	function automatic bin_req_t hit_req(logic [WORD_W-1:0] pos, int unsigned slen, bit unm,
		int unsigned samp, int unsigned cnt);
		bin_req_t it;
		it      = random_fields();
		it.req  = REQ_HIT;
		it.pos  = pos;
		it.slen = SLEN_W'(slen);
		it.unm  = unm;
		it.samp = SAMP_W'(samp);
		it.cnt  = CNT_W'(cnt);
		return it;
	endfunction

	function automatic bin_req_t read_req(int unsigned qbin, int unsigned samp);
		bin_req_t it;
		it      = random_fields();
		it.req  = REQ_READ;
		it.qbin = BIDX_W'(qbin);
		it.samp = SAMP_W'(samp);
		return it;
	endfunction

	// Hit aimed at the loaded table, often right at a chimera threshold
	function automatic bin_req_t make_hit();
		bin_req_t it;
		int unsigned roll, b;
		logic [WORD_W-1:0] lo_pos, hi_pos;
		longint aim;
		it     = random_fields();
		it.req = REQ_HIT;
		it.unm = 1'b0;
		roll   = $urandom_range(99, 0);
		if (roll < 8) begin
			it.unm = 1'b1;
		end else if (roll < 16) begin
			if (plan_starts[0] != 0) it.pos = $urandom_range(plan_starts[0] - 1, 0);
		end else if (roll < 20) begin
			it.pos = WORD_MAX;
		end else if (roll < 84) begin
			b      = $urandom_range(cur_bins - 1, 0);
			lo_pos = plan_starts[b];
			hi_pos = WORD_MAX;
			if (b + 1 < cur_bins)
				hi_pos = (plan_starts[b + 1] > lo_pos) ? plan_starts[b + 1] - 1 : lo_pos;
			it.pos = $urandom_range(hi_pos, lo_pos);
			if (b + 1 < cur_bins && $urandom_range(1, 0) == 1) begin
				aim = longint'(plan_starts[b + 1]) - longint'(it.pos) + longint'(cur_tol) +
					longint'($urandom_range(4, 0)) - 2;
				if (aim < 0) aim = 0;
				if (aim > 65535) aim = 65535;
				it.slen = SLEN_W'(aim);
			end
		end
		if ($urandom_range(99, 0) < 88) it.samp = SAMP_W'($urandom_range(cur_samples - 1, 0));
		roll = $urandom_range(99, 0);
		if (roll < 10) it.cnt = '1;
		else if (roll < 15) it.cnt = '0;
		return it;
	endfunction

	function automatic bin_req_t random_item();
		bin_req_t it;
		int unsigned roll;
		roll = $urandom_range(99, 0);
		if (roll < 70) begin
			it = make_hit();
		end else if (roll < 86) begin
			it = read_req($urandom_range(cur_bins - 1, 0), $urandom_range(cur_samples - 1, 0));
			if (roll >= 82) it = read_req($urandom_range(1023, 0), $urandom_range(63, 0));
		end else if (roll < 96) begin
			// stray load; may leave the table unsorted
			it = random_fields();
			it.req = REQ_LOAD;
		end else begin
			it = random_fields();
			it.req = REQ_UNKNOWN;
		end
		return it;
	endfunction

	// Load a non-descending table into every entry in use
	task automatic load_table(int unsigned step_max);
		logic [WORD_W+10:0] acc;
		acc = ($urandom_range(3, 0) == 0) ? '0 : (WORD_W+11)'($urandom_range(5000, 1));
		for (int i = 0; i < cur_bins; i++) begin
			plan_starts[i] = (acc > WORD_MAX) ? WORD_MAX : acc[WORD_W-1:0];
			send_item(load_req(i, plan_starts[i]));
			if ($urandom_range(15, 0) != 0) acc += $urandom_range(step_max, 1);
		end
	endtask

	task automatic run_phase(int unsigned nbins, int unsigned samples, int unsigned tol,
		int unsigned step_max, int unsigned items, int unsigned hold_at);
		write_config(nbins, samples, tol);
		load_table(step_max);
		for (int n = 0; n < items; n++) begin
			if (hold_at != 0 && n == hold_at) hold_left = HOLD_CYCLES;
			send_item(random_item());
		end
	endtask

	initial begin
		bin_req_t odd;
		int unsigned nbins, samples, tol, step_max, roll;

		// reset, then wait out the matrix clearing sweep
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		@(negedge clk);

		// directed: four bins, full sample width, no tolerance
		write_config(4, 64, 0);
		send_item(load_req(0, 32'd100));
		send_item(load_req(1, 32'd200));
		send_item(load_req(2, 32'd300));
		send_item(load_req(3, 32'hFFFF_FF00));
		send_item(hit_req(32'd150, 10, 1'b1, 0, 7));
		send_item(hit_req(32'd99, 1, 1'b0, 0, 7));
		send_item(hit_req(32'd0, 0, 1'b0, 0, 0));
		// read ends exactly at the next start, then one base past it
		send_item(hit_req(32'd100, 100, 1'b0, 0, 1));
		send_item(hit_req(32'd150, 51, 1'b0, 63, 5));
		send_item(hit_req(32'd200, 100, 1'b0, 63, 65535));
		// last bin is never checked for chimeras
		send_item(hit_req(32'hFFFF_FFFF, 65535, 1'b0, 63, 65535));
		send_item(read_req(1, 63));
		send_item(read_req(3, 63));
		send_item(read_req(1023, 0));
		odd = random_fields();
		odd.req = REQ_UNKNOWN;
		send_item(odd);

		// directed: narrow stride reinterprets cells, widest tolerance
		write_config(4, 3, 65535);
		send_item(hit_req(32'd250, 10, 1'b0, 5, 9));
		send_item(hit_req(32'd150, 65535, 1'b0, 1, 9));
		send_item(read_req(1, 0));
		send_item(read_req(2, 5));
		send_item(read_req(4, 0));
		send_item(load_req(1023, WORD_MAX));

		// extremes of the configuration
		run_phase(1024, 64, 65535, 4000000, 50, 0);
		run_phase(1, 1, 0, 64, 30, 0);

		// random settings, small tables
		for (int p = 0; p < 4; p++) begin
			nbins = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 25) : $urandom_range(24, 2);
			samples = $urandom_range(64, 1);
			roll = $urandom_range(2, 0);
			tol = (roll == 0) ? 0 : (roll == 1) ? $urandom_range(200, 0) : $urandom_range(65535, 0);
			case ($urandom_range(3, 0))
				0: step_max = 64;
				1: step_max = 4096;
				2: step_max = 70000;
				default: step_max = 4000000;
			endcase
			gap_on   = (p != 3);
			stall_on = (p != 3);
			run_phase(nbins, samples, tol, step_max, 25, (p == 1) ? 10 : 0);
		end

		// hammer one cell with the largest count, with no idling at all
		write_config(1, 1, 0);
		gap_on   = 1'b0;
		stall_on = 1'b0;
		send_item(load_req(0, 32'd0));
		repeat (HAMMER_HITS)
			send_item(hit_req($urandom(), $urandom_range(65535, 0), 1'b0, 0, 65535));
		send_item(read_req(0, 0));

		drain();
		if (ledger.mismatches == 0 && ledger.results_due.size() == 0) begin
			$display("interval_bin_count_matrix verification clean");
		end else begin
			$display("interval_bin_count_matrix verification failed");
		end
		$finish;
	end

endmodule
